// File: design/segment_segment_intersection_assert.svh
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Concurrent assertion helpers used by the work queue; they expand to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH
`ifndef SYNTH
`define SSI_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define SSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSI_ASSERT_ALWAYS(label, clk, rst, expr)
`define SSI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/ssi_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared types, widths and result kind codes.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int COORD_W = 16;
  localparam int Q_W     = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = 34;
  localparam int N_W     = SUM_W + DIFF_W;
  localparam int DEN_W   = SUM_W;
  localparam int QUO_W   = 34;
  localparam int REM_W   = DEN_W + 1;

  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_CROSS      = 3'd1;
  localparam logic [2:0] KIND_TOUCH      = 3'd2;
  localparam logic [2:0] KIND_COLL_TOUCH = 3'd3;
  localparam logic [2:0] KIND_OVERLAP    = 3'd4;
  localparam logic [2:0] KIND_APART      = 3'd5;
  localparam logic [2:0] KIND_INSIDE     = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // One classified pair on its way to the divider side.
  typedef struct packed {
    logic [2:0]               kind;
    logic [Q_W-1:0]           px;
    logic [Q_W-1:0]           py;
    logic [Q_W-1:0]           qx;
    logic [Q_W-1:0]           qy;
    logic signed [N_W-1:0]    nx;
    logic signed [N_W-1:0]    ny;
    logic signed [SUM_W-1:0]  den;
  } work_t;

  function automatic logic [Q_W-1:0] to_q16(coord_t v);
    return {v, 16'h0000};
  endfunction

endpackage

// File: design/ssi_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Four-stage pipeline: capture, cross products, signs, classification.
// ----------------------------------------------------------------------------
module ssi_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  ssi_pkg::point_t a,
  input  ssi_pkg::point_t b,
  input  ssi_pkg::point_t c,
  input  ssi_pkg::point_t d,
  output logic           out_valid,
  output ssi_pkg::work_t out_work,
  input  logic           out_full
);
  import ssi_pkg::*;

  logic adv;
  assign adv = !(out_valid && out_full);
  assign full = !adv;

  // Stage 1: captured points.
  logic   s1_valid;
  point_t s1_a, s1_b, s1_c, s1_d;

  // Stage 2: products.
  logic                     s2_valid;
  point_t                   s2_a, s2_b, s2_c, s2_d;
  logic signed [PROD_W-1:0] prod [18];

  // Stage 3: signs and the crossing fraction terms.
  logic                    s3_valid;
  point_t                  s3_a, s3_b, s3_c, s3_d;
  logic                    oc_pos, oc_neg, od_pos, od_neg;
  logic                    oa_pos, oa_neg, ob_pos, ob_neg;
  logic                    bac, bad, bbc, bbd, den_zero;
  logic signed [SUM_W-1:0] s3_num, s3_den;

  logic s4_valid;
  assign out_valid = s4_valid;

  logic signed [DIFF_W-1:0] bax, bay, cax, cay, dax, day, dcx, dcy, bcx, bcy;
  logic signed [DIFF_W-1:0] cbx, cby, dbx, dby;

  function automatic logic signed [DIFF_W-1:0] sub(coord_t p, coord_t q);
    return {p[COORD_W-1], p} - {q[COORD_W-1], q};
  endfunction

  always_comb begin
    bax = sub(s1_b.x, s1_a.x);
    bay = sub(s1_b.y, s1_a.y);
    cax = sub(s1_c.x, s1_a.x);
    cay = sub(s1_c.y, s1_a.y);
    dax = sub(s1_d.x, s1_a.x);
    day = sub(s1_d.y, s1_a.y);
    dcx = sub(s1_d.x, s1_c.x);
    dcy = sub(s1_d.y, s1_c.y);
    bcx = sub(s1_b.x, s1_c.x);
    bcy = sub(s1_b.y, s1_c.y);
    cbx = sub(s1_c.x, s1_b.x);
    cby = sub(s1_c.y, s1_b.y);
    dbx = sub(s1_d.x, s1_b.x);
    dby = sub(s1_d.y, s1_b.y);
  end

  logic signed [SUM_W-1:0] oc, od, oa, ob, e1c, e1d, e2c, e2d, den;
  always_comb begin
    oc  = prod[0] - prod[1];
    od  = prod[2] - prod[3];
    oa  = prod[4] - prod[5];
    ob  = prod[6] - prod[7];
    e1c = prod[8] + prod[9];
    e1d = prod[10] + prod[11];
    e2c = prod[12] + prod[13];
    e2d = prod[14] + prod[15];
    den = prod[17] - prod[16];
  end

  // Classification on stage 3 results.
  logic [2:0] kind_c;
  point_t     pa, pb;
  logic       h1, h2;
  logic       oc_zero, od_zero, oa_zero, ob_zero;
  point_t     pon;
  logic       pon_ab, pon_ba;

  always_comb begin
    oc_zero = !oc_pos && !oc_neg;
    od_zero = !od_pos && !od_neg;
    oa_zero = !oa_pos && !oa_neg;
    ob_zero = !ob_pos && !ob_neg;
    pon     = oc_zero ? s3_c : s3_d;
    pon_ab  = oc_zero ? bac : bad;
    pon_ba  = oc_zero ? bbc : bbd;
    kind_c  = KIND_NONE;
    pa      = s3_a;
    pb      = s3_b;
    h1      = 1'b0;
    h2      = 1'b0;
    if ((oc_zero && !od_zero) || (!oc_zero && od_zero)) begin
      // One end of segment two lies on the line through segment one.
      if (!pon_ab && !pon_ba) begin
        kind_c = KIND_INSIDE;
        pa = pon;
        h1 = 1'b1;
      end else if (pon == s3_a || pon == s3_b) begin
        kind_c = KIND_TOUCH;
        pa = pon;
        h1 = 1'b1;
      end else begin
        kind_c = KIND_APART;
      end
    end else if (!oc_zero) begin
      if ((oc_pos && od_pos) || (oc_neg && od_neg)) begin
        kind_c = KIND_NONE;
      end else if (oc_pos ? oa_pos : oa_neg) begin
        kind_c = KIND_NONE;
      end else if (oa_zero) begin
        kind_c = KIND_TOUCH;
        pa = s3_a;
        h1 = 1'b1;
      end else if (ob_zero) begin
        kind_c = KIND_TOUCH;
        pa = s3_b;
        h1 = 1'b1;
      end else if (oc_pos ? ob_neg : ob_pos) begin
        kind_c = KIND_NONE;
      end else if (den_zero) begin
        kind_c = KIND_NONE;
      end else begin
        kind_c = KIND_CROSS;
        pa = s3_a;
        h1 = 1'b1;
      end
    end else begin
      // All four points on one line.
      h1 = 1'b1;
      h2 = 1'b1;
      kind_c = KIND_OVERLAP;
      if (bac) begin
        if (bad) begin
          h2 = 1'b0;
          if (s3_b == s3_c || s3_b == s3_d) begin
            kind_c = KIND_COLL_TOUCH;
            pa = s3_b;
          end else begin
            kind_c = KIND_APART;
            h1 = 1'b0;
          end
        end else if (bbd) begin
          pa = s3_a;
          pb = s3_b;
        end else begin
          pa = s3_d;
          pb = s3_b;
        end
      end else if (bbc) begin
        if (bbd) begin
          h2 = 1'b0;
          if (s3_a == s3_c || s3_a == s3_d) begin
            kind_c = KIND_COLL_TOUCH;
            pa = s3_a;
          end else begin
            kind_c = KIND_APART;
            h1 = 1'b0;
          end
        end else if (bad) begin
          pa = s3_a;
          pb = s3_b;
        end else begin
          pa = s3_a;
          pb = s3_d;
        end
      end else if (bad) begin
        pa = s3_c;
        pb = s3_b;
      end else if (bbd) begin
        pa = s3_a;
        pb = s3_c;
      end else begin
        pa = s3_c;
        pb = s3_d;
      end
    end
  end

  logic signed [DIFF_W-1:0] bax3, bay3;
  logic signed [N_W-1:0]    mul_x, mul_y;
  always_comb begin
    bax3  = sub(s3_b.x, s3_a.x);
    bay3  = sub(s3_b.y, s3_a.y);
    mul_x = s3_num * bax3;
    mul_y = s3_num * bay3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a <= a;
      s1_b <= b;
      s1_c <= c;
      s1_d <= d;

      s2_a <= s1_a;
      s2_b <= s1_b;
      s2_c <= s1_c;
      s2_d <= s1_d;
      prod[0]  <= bax * cay;
      prod[1]  <= bay * cax;
      prod[2]  <= bax * day;
      prod[3]  <= bay * dax;
      prod[4]  <= dcy * cax;
      prod[5]  <= dcx * cay;
      prod[6]  <= dcx * bcy;
      prod[7]  <= dcy * bcx;
      prod[8]  <= cbx * bax;
      prod[9]  <= cby * bay;
      prod[10] <= dbx * bax;
      prod[11] <= dby * bay;
      prod[12] <= cax * bax;
      prod[13] <= cay * bay;
      prod[14] <= dax * bax;
      prod[15] <= day * bay;
      prod[16] <= bax * dcy;
      prod[17] <= bay * dcx;

      s3_a <= s2_a;
      s3_b <= s2_b;
      s3_c <= s2_c;
      s3_d <= s2_d;
      oc_pos <= !oc[SUM_W-1] && (oc != '0);
      oc_neg <= oc[SUM_W-1];
      od_pos <= !od[SUM_W-1] && (od != '0);
      od_neg <= od[SUM_W-1];
      oa_pos <= !oa[SUM_W-1] && (oa != '0);
      oa_neg <= oa[SUM_W-1];
      ob_pos <= !ob[SUM_W-1] && (ob != '0);
      ob_neg <= ob[SUM_W-1];
      bac <= !e1c[SUM_W-1];
      bad <= !e1d[SUM_W-1];
      // Beyond a seen from b uses the negated sum, so test for at most zero.
      bbc <= e2c[SUM_W-1] || (e2c == '0);
      bbd <= e2d[SUM_W-1] || (e2d == '0);
      den_zero <= (den == '0);
      s3_num <= -oa;
      s3_den <= den;

      out_work.kind <= kind_c;
      out_work.px   <= h1 ? to_q16(pa.x) : '0;
      out_work.py   <= h1 ? to_q16(pa.y) : '0;
      out_work.qx   <= h2 ? to_q16(pb.x) : '0;
      out_work.qy   <= h2 ? to_q16(pb.y) : '0;
      out_work.nx   <= mul_x;
      out_work.ny   <= mul_y;
      out_work.den  <= s3_den;
    end
  end

endmodule

// File: design/ssi_queue.sv
// ----------------------------------------------------------------------------
// Segment intersection work queue
// Small FIFO that decouples the classifier from the divider pipeline.
// ----------------------------------------------------------------------------
module ssi_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ssi_pkg::work_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output ssi_pkg::work_t rd_data,
  output logic           empty
);
  import ssi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

`include "segment_segment_intersection_assert.svh"

  `SSI_ASSERT_ALWAYS(a_no_overflow, clk, rst, !(wr_en && full))
  `SSI_ASSERT_ALWAYS(a_no_underflow, clk, rst, !(rd_en && empty))
  `SSI_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `SSI_ASSERT_NEXT(a_fill_shows, clk, rst, wr_en && !rd_en, !empty)

endmodule

// File: design/ssi_back.sv
// ----------------------------------------------------------------------------
// Segment intersection back end
// Sign and magnitude preparation, a one-bit-per-stage restoring divider for
// both crossing coordinates, rounding and the result register.
// ----------------------------------------------------------------------------
module ssi_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ssi_pkg::work_t in_work,
  output logic           in_pop,
  output logic           empty,
  input  logic           pop,
  output logic [2:0]     kind,
  output logic [31:0]    first_x,
  output logic [31:0]    first_y,
  output logic [31:0]    second_x,
  output logic [31:0]    second_y
);
  import ssi_pkg::*;

  typedef struct packed {
    logic [2:0]       kind;
    logic [Q_W-1:0]   px;
    logic [Q_W-1:0]   py;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rx;
    logic [REM_W-1:0] ry;
    logic [QUO_W-1:0] lox;
    logic [QUO_W-1:0] loy;
    logic [QUO_W-1:0] qtx;
    logic [QUO_W-1:0] qty;
    logic             negx;
    logic             negy;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t             r;
    logic [REM_W-1:0] tx;
    logic [REM_W-1:0] ty;
    r  = s;
    tx = {s.rx[REM_W-2:0], s.lox[QUO_W-1]};
    ty = {s.ry[REM_W-2:0], s.loy[QUO_W-1]};
    if (tx >= {1'b0, s.den}) begin
      r.rx  = tx - {1'b0, s.den};
      r.qtx = {s.qtx[QUO_W-2:0], 1'b1};
    end else begin
      r.rx  = tx;
      r.qtx = {s.qtx[QUO_W-2:0], 1'b0};
    end
    if (ty >= {1'b0, s.den}) begin
      r.ry  = ty - {1'b0, s.den};
      r.qty = {s.qty[QUO_W-2:0], 1'b1};
    end else begin
      r.ry  = ty;
      r.qty = {s.qty[QUO_W-2:0], 1'b0};
    end
    r.lox = {s.lox[QUO_W-2:0], 1'b0};
    r.loy = {s.loy[QUO_W-2:0], 1'b0};
    return r;
  endfunction

  logic adv;
  logic out_valid;
  assign adv    = !out_valid || pop;
  assign in_pop = adv && in_valid;
  assign empty  = !out_valid;

  // Preparation: magnitudes and the sign of each quotient.
  logic [N_W-1:0]    absx, absy;
  logic [N_W+15:0]   dvx, dvy;
  logic              den_neg;
  div_t              prep;
  always_comb begin
    den_neg   = in_work.den[SUM_W-1];
    absx      = in_work.nx[N_W-1] ? -in_work.nx : in_work.nx;
    absy      = in_work.ny[N_W-1] ? -in_work.ny : in_work.ny;
    dvx       = {absx, 16'h0000};
    dvy       = {absy, 16'h0000};
    prep.kind = in_work.kind;
    prep.px   = in_work.px;
    prep.py   = in_work.py;
    prep.qx   = in_work.qx;
    prep.qy   = in_work.qy;
    prep.den  = den_neg ? -in_work.den : in_work.den;
    prep.rx   = REM_W'(dvx[N_W+15:QUO_W]);
    prep.ry   = REM_W'(dvy[N_W+15:QUO_W]);
    prep.lox  = dvx[QUO_W-1:0];
    prep.loy  = dvy[QUO_W-1:0];
    prep.qtx  = '0;
    prep.qty  = '0;
    prep.negx = den_neg ? (!in_work.nx[N_W-1] && in_work.nx != '0) : in_work.nx[N_W-1];
    prep.negy = den_neg ? (!in_work.ny[N_W-1] && in_work.ny != '0) : in_work.ny[N_W-1];
  end

  div_t st [QUO_W+1];
  logic vld [QUO_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QUO_W; i++) begin
        vld[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= QUO_W; i++) begin
        vld[i] <= vld[i-1];
      end
      out_valid <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= prep;
      for (int i = 1; i <= QUO_W; i++) begin
        st[i] <= div_step(st[i-1]);
      end
    end
  end

  // Round to nearest with halves away from zero, then apply the sign.
  div_t           fin;
  logic           rndx, rndy;
  logic [Q_W-1:0] resx, resy, valx, valy;
  always_comb begin
    fin  = st[QUO_W];
    rndx = {fin.rx, 1'b0} >= {2'b00, fin.den};
    rndy = {fin.ry, 1'b0} >= {2'b00, fin.den};
    resx = fin.qtx[Q_W-1:0] + Q_W'(rndx);
    resy = fin.qty[Q_W-1:0] + Q_W'(rndy);
    valx = fin.negx ? -resx : resx;
    valy = fin.negy ? -resy : resy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind     <= fin.kind;
      first_x  <= (fin.kind == KIND_CROSS) ? fin.px + valx : fin.px;
      first_y  <= (fin.kind == KIND_CROSS) ? fin.py + valy : fin.py;
      second_x <= fin.qx;
      second_y <= fin.qy;
    end
  end

endmodule

// File: design/segment_segment_intersection.sv
// ----------------------------------------------------------------------------
// Segment segment intersection
// Classifies how two integer segments meet and returns the meeting points.
// ----------------------------------------------------------------------------
// Usage:
// The input side is a queue write port: drive the eight coordinates and raise
// push; a beat is taken on a rising edge where push is high and full is low.
// The result side is a queue read port: while empty is low the oldest result
// (kind and four Q16.16 point fields) is on the outputs, and a beat leaves on
// a rising edge where pop is high.
// Throughput is one pair per cycle when nothing stalls. Between an input
// beat and its result lie four classifier stages, the work queue, one
// preparation stage, 34 divider stages (one quotient bit each, both
// coordinates side by side) and the result register. The divider pipeline
// sets the one-per-cycle rate.
// When the receiver stalls, the divider pipeline holds, the work queue fills,
// and then the classifier holds and full rises; no beat is lost.
// Synchronous reset empties every stage and the queue; nothing else is needed
// before the first beat.
// ----------------------------------------------------------------------------
module segment_segment_intersection #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  ax,
  input  logic signed [15:0]  ay,
  input  logic signed [15:0]  bx,
  input  logic signed [15:0]  by_coord,
  input  logic signed [15:0]  cx,
  input  logic signed [15:0]  cy,
  input  logic signed [15:0]  dx,
  input  logic signed [15:0]  dy,
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          kind,
  output logic signed [31:0]  first_x,
  output logic signed [31:0]  first_y,
  output logic signed [31:0]  second_x,
  output logic signed [31:0]  second_y
);
  import ssi_pkg::*;

  point_t pa, pb, pc, pd;
  assign pa = '{x: ax, y: ay};
  assign pb = '{x: bx, y: by_coord};
  assign pc = '{x: cx, y: cy};
  assign pd = '{x: dx, y: dy};

  // Classifier to queue.
  logic  f_valid;
  work_t f_work;
  logic  q_full;
  logic  q_wr;

  // Queue to divider side.
  work_t q_data;
  logic  q_empty;
  logic  q_rd;

  assign q_wr = f_valid && !q_full;

  ssi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .a         (pa),
    .b         (pb),
    .c         (pc),
    .d         (pd),
    .out_valid (f_valid),
    .out_work  (f_work),
    .out_full  (q_full)
  );

  ssi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (f_work),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // The back end's result register doubles as the output port register.
  ssi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_work  (q_data),
    .in_pop   (q_rd),
    .empty    (empty),
    .pop      (pop),
    .kind     (kind),
    .first_x  (first_x),
    .first_y  (first_y),
    .second_x (second_x),
    .second_y (second_y)
  );

endmodule
